// ===== design/shhe_pkg.sv =====
`timescale 1ns / 1ps
// Package for the string hash hex expander: sequencer states, arithmetic
// constants and the nibble-to-ASCII digit lookup. No dependencies.
package shhe_pkg;

    localparam int unsigned HexCharsDefault = 64;

    localparam logic [31:0] HASH_INIT = 32'd5381;
    localparam logic [31:0] HASH_MUL  = 32'd33;
    localparam logic [31:0] SEED_MUL  = 32'd2654435761;
    localparam logic [31:0] SEED_ADD  = 32'd1;
    localparam logic [31:0] LCG_MUL   = 32'd1103515245;
    localparam logic [31:0] LCG_ADD   = 32'd12345;

    typedef enum logic {
        ST_IDLE,
        ST_GEN
    } t_state;

    // Map one nibble to a lowercase ASCII hex digit.
    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        logic [6:0] ch;
        case (nib)
            4'h0: ch = 7'h30;
            4'h1: ch = 7'h31;
            4'h2: ch = 7'h32;
            4'h3: ch = 7'h33;
            4'h4: ch = 7'h34;
            4'h5: ch = 7'h35;
            4'h6: ch = 7'h36;
            4'h7: ch = 7'h37;
            4'h8: ch = 7'h38;
            4'h9: ch = 7'h39;
            4'ha: ch = 7'h61;
            4'hb: ch = 7'h62;
            4'hc: ch = 7'h63;
            4'hd: ch = 7'h64;
            4'he: ch = 7'h65;
            4'hf: ch = 7'h66;
            default: ch = 7'h30;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/string_hash_hex_expander.sv =====
`timescale 1ns / 1ps
// String hash hex expander top level: djb2 key hash, seeded LCG and hex
// digit output. Depends on shhe_pkg.

// Feed a key one byte per beat with i_end_of_key low; each accepted byte
// is folded into a 32-bit djb2 hash (start 5381, times 33 plus
// byte). A beat with i_end_of_key high (key_byte ignored, empty keys allowed)
// seeds a generator with hash * 2654435761 + 1 and the block then emits
// HEX_CHARS lowercase ASCII hex digits, one per cycle when the output is not
// stalled, each taken from bits 19..16 of the generator after one LCG step
// (times 1103515245 plus 12345). o_last_char marks the final digit, and the
// hash returns to 5381 for the next key. All three products go through one
// shared 32x32 multiply-add unit, one product per cycle unless the output
// stalls. Input stall stays high from the end beat until the last digit is
// loaded into the output register; the next key byte can be taken while
// that last digit still waits downstream.
module string_hash_hex_expander
    import shhe_pkg::*;
#(
    parameter int unsigned HEX_CHARS = HexCharsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_key_byte,
    input  logic       i_end_of_key,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_hex_char,
    output logic       o_last_char
);

    localparam int unsigned CntW = (HEX_CHARS > 1) ? $clog2(HEX_CHARS) : 1;
    localparam logic [CntW-1:0] LastCnt = CntW'(HEX_CHARS - 1);

    t_state          r_state, n_state;
    logic [31:0]     r_hash, n_hash;
    logic [31:0]     r_gen, n_gen;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic [6:0]      r_hex, n_hex;
    logic            r_last, n_last;

    // shared multiply-add unit, low 32 bits of the product only
    logic [31:0] w_mul_a, w_mul_b, w_add;
    logic [31:0] w_prod;
    logic [31:0] w_mac;

    logic w_in_acc;
    logic w_out_free;

    assign w_prod = w_mul_a * w_mul_b;
    assign w_mac  = w_prod + w_add;

    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_gen       = r_gen;
        n_cnt       = r_cnt;
        n_hex       = r_hex;
        n_last      = r_last;
        // drop the output beat once taken
        n_out_valid = r_out_valid && i_out_stall;
        w_mul_a     = r_hash;
        w_mul_b     = HASH_MUL;
        w_add       = {24'd0, i_key_byte};

        case (r_state)
            ST_IDLE: begin
                if (i_end_of_key) begin
                    w_mul_b = SEED_MUL;
                    w_add   = SEED_ADD;
                end
                if (w_in_acc) begin
                    if (i_end_of_key) begin
                        // seed the generator and rearm the hash
                        n_gen   = w_mac;
                        n_hash  = HASH_INIT;
                        n_cnt   = '0;
                        n_state = ST_GEN;
                    end else begin
                        n_hash = w_mac;
                    end
                end
            end
            ST_GEN: begin
                w_mul_a = r_gen;
                w_mul_b = LCG_MUL;
                w_add   = LCG_ADD;
                // advance only when the output register can take a digit
                if (w_out_free) begin
                    n_gen       = w_mac;
                    n_hex       = hex_digit(w_mac[19:16]);
                    n_last      = (r_cnt == LastCnt);
                    n_out_valid = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == LastCnt) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= HASH_INIT;
            r_gen       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_gen       <= n_gen;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload, held while stalled
    always_ff @(posedge i_clk) begin
        r_hex  <= n_hex;
        r_last <= n_last;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hex_char  = r_hex;
    assign o_last_char = r_last;

endmodule
